// ===== src/scd_pkg.sv =====
// ----------------------------------------------------------------------------
// scd_pkg - shared types and constants
// Fixed-point formats, config register set, controller states and the
// command bundle that drives the datapath of the slip-compensated drive core.
// ----------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

  localparam int FRAC_BITS = 12;          // Q8.12 speeds
  localparam int GAIN_FRAC = 16;          // Q0.16 gains
  localparam int SPD_W     = 20;
  localparam int SLIP_W    = 15;
  localparam int ERR_W     = 21;
  localparam int ESUM_W    = 20;
  localparam int DIFF_W    = 22;

  // shared multiplier operands and product
  localparam int MA_W      = 24;
  localparam int MB_W      = 17;
  localparam int PROD_W    = MA_W + MB_W;
  localparam int ACC_W     = PROD_W + 3;

  localparam int SLIP_ONE  = 1 << FRAC_BITS;
  localparam int SLIP_MAX  = 2 * SLIP_ONE;
  localparam int SLIP_MIN  = -SLIP_ONE;
  localparam int SPD_MAX   = (1 << (SPD_W - 1)) - 1;
  localparam int SPD_MIN   = -(1 << (SPD_W - 1));

  localparam int IN_DATA_W  = 104;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_INT_LIMIT   = 3'd3,
    REG_HALF_BASE   = 3'd4,
    REG_CMD_THRESH  = 3'd5,
    REG_WHEEL_THRESH = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [18:0] integral_limit;
    logic [12:0] half_wheel_base;
    logic [11:0] command_threshold;
    logic [11:0] wheel_threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_P,
    MUL_I,
    MUL_D,
    MUL_ANG,
    MUL_HWB
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC,
    ST_SLIP,
    ST_MUL_ANG,
    ST_MUL_HWB,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     err_step;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     diff_load;
    logic     acc_load;
    logic     acc_add;
    logic     slip_step;
    logic     out_load;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== src/scd_regs.sv =====
// ----------------------------------------------------------------------------
// scd_regs - configuration register file
// APB-style write/read of the seven controller settings.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [scd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [scd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [scd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  output scd_pkg::cfg_t                       cfg
);

  scd_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = scd_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p            <= 16'd655;
      cfg.gain_i            <= 16'd0;
      cfg.gain_d            <= 16'd0;
      cfg.integral_limit    <= 19'd40960;
      cfg.half_wheel_base   <= 13'd1434;
      cfg.command_threshold <= 12'd41;
      cfg.wheel_threshold   <= 12'd20;
    end else if (wr_en) begin
      unique case (idx)
        scd_pkg::REG_GAIN_P:       cfg.gain_p            <= pwdata[15:0];
        scd_pkg::REG_GAIN_I:       cfg.gain_i            <= pwdata[15:0];
        scd_pkg::REG_GAIN_D:       cfg.gain_d            <= pwdata[15:0];
        scd_pkg::REG_INT_LIMIT:    cfg.integral_limit    <= pwdata[18:0];
        scd_pkg::REG_HALF_BASE:    cfg.half_wheel_base   <= pwdata[12:0];
        scd_pkg::REG_CMD_THRESH:   cfg.command_threshold <= pwdata[11:0];
        scd_pkg::REG_WHEEL_THRESH: cfg.wheel_threshold   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      scd_pkg::REG_GAIN_P:       prdata = {16'd0, cfg.gain_p};
      scd_pkg::REG_GAIN_I:       prdata = {16'd0, cfg.gain_i};
      scd_pkg::REG_GAIN_D:       prdata = {16'd0, cfg.gain_d};
      scd_pkg::REG_INT_LIMIT:    prdata = {13'd0, cfg.integral_limit};
      scd_pkg::REG_HALF_BASE:    prdata = {19'd0, cfg.half_wheel_base};
      scd_pkg::REG_CMD_THRESH:   prdata = {20'd0, cfg.command_threshold};
      scd_pkg::REG_WHEEL_THRESH: prdata = {20'd0, cfg.wheel_threshold};
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/scd_ctrl.sv =====
// ----------------------------------------------------------------------------
// scd_ctrl - tick sequencer
// Walks one tick through error, PID multiplies, slip update and wheel
// scaling, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_ctrl (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output scd_pkg::dp_cmd_t cmd
);

  scd_pkg::state_t state, state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      scd_pkg::ST_IDLE:    if (in_valid) state_next = scd_pkg::ST_ERR;
      scd_pkg::ST_ERR:     state_next = scd_pkg::ST_MUL_P;
      scd_pkg::ST_MUL_P:   state_next = scd_pkg::ST_MUL_I;
      scd_pkg::ST_MUL_I:   state_next = scd_pkg::ST_MUL_D;
      scd_pkg::ST_MUL_D:   state_next = scd_pkg::ST_ACC;
      scd_pkg::ST_ACC:     state_next = scd_pkg::ST_SLIP;
      scd_pkg::ST_SLIP:    state_next = scd_pkg::ST_MUL_ANG;
      scd_pkg::ST_MUL_ANG: state_next = scd_pkg::ST_MUL_HWB;
      scd_pkg::ST_MUL_HWB: state_next = scd_pkg::ST_OUT;
      scd_pkg::ST_OUT:     if (out_free) state_next = scd_pkg::ST_IDLE;
      default:             state_next = scd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mul_sel = scd_pkg::MUL_P;
    in_ready = 1'b0;
    unique case (state)
      scd_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      scd_pkg::ST_ERR: cmd.err_step = 1'b1;
      scd_pkg::ST_MUL_P: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = scd_pkg::MUL_P;
        cmd.diff_load = 1'b1;
      end
      scd_pkg::ST_MUL_I: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = scd_pkg::MUL_I;
        cmd.acc_load = 1'b1;
      end
      scd_pkg::ST_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = scd_pkg::MUL_D;
        cmd.acc_add = 1'b1;
      end
      scd_pkg::ST_ACC:  cmd.acc_add   = 1'b1;
      scd_pkg::ST_SLIP: cmd.slip_step = 1'b1;
      scd_pkg::ST_MUL_ANG: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = scd_pkg::MUL_ANG;
      end
      scd_pkg::ST_MUL_HWB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = scd_pkg::MUL_HWB;
      end
      scd_pkg::ST_OUT: cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/scd_dp.sv =====
// ----------------------------------------------------------------------------
// scd_dp - controller datapath
// Target and odometry state, yaw error, clamped error sum, one shared
// multiplier with accumulator, slip clamp and wheel command saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire scd_pkg::dp_cmd_t                  cmd,
  input  wire scd_pkg::cfg_t                     cfg,
  input  wire logic                              cmd_valid,
  input  wire logic signed [scd_pkg::SPD_W-1:0]  cmd_linear,
  input  wire logic signed [scd_pkg::SPD_W-1:0]  cmd_angular,
  input  wire logic                              odom_valid,
  input  wire logic signed [scd_pkg::SPD_W-1:0]  odom_angular,
  input  wire logic signed [scd_pkg::SPD_W-1:0]  wheel_right_meas,
  input  wire logic signed [scd_pkg::SPD_W-1:0]  wheel_left_meas,
  output logic signed      [scd_pkg::SPD_W-1:0]  wheel_right_cmd,
  output logic signed      [scd_pkg::SPD_W-1:0]  wheel_left_cmd,
  output logic signed      [scd_pkg::SLIP_W-1:0] slip_value
);

  localparam int SPD_W  = scd_pkg::SPD_W;
  localparam int SLIP_W = scd_pkg::SLIP_W;
  localparam int ERR_W  = scd_pkg::ERR_W;
  localparam int ESUM_W = scd_pkg::ESUM_W;
  localparam int DIFF_W = scd_pkg::DIFF_W;
  localparam int MA_W   = scd_pkg::MA_W;
  localparam int MB_W   = scd_pkg::MB_W;
  localparam int PROD_W = scd_pkg::PROD_W;
  localparam int ACC_W  = scd_pkg::ACC_W;
  localparam int FRAC   = scd_pkg::FRAC_BITS;
  localparam int GFRAC  = scd_pkg::GAIN_FRAC;
  localparam int Q_W    = ACC_W - GFRAC;
  localparam int T_W    = Q_W + 1;
  localparam int D_W    = PROD_W - FRAC;
  localparam int W_W    = D_W + 1;

  // tick state
  logic signed [SPD_W-1:0]  tgt_lin, tgt_ang, prev_ang;
  logic signed [SPD_W-1:0]  odom_now, odom_before;
  logic signed [SPD_W-1:0]  right_meas, left_meas;
  logic signed [SLIP_W-1:0] slip;
  logic signed [ESUM_W-1:0] err_sum;
  logic signed [ERR_W-1:0]  last_err;

  // per-tick working registers
  logic                     move;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  function automatic logic [SPD_W-1:0] mag(input logic signed [SPD_W-1:0] v);
    logic [SPD_W-1:0] m;
    m = v[SPD_W-1] ? SPD_W'(-v) : SPD_W'(v);
    return m;
  endfunction

  // error and move condition
  logic signed [SPD_W:0]    odom_sum;
  logic signed [SPD_W-1:0]  filt;
  logic signed [ERR_W-1:0]  err_raw, err_next;
  logic signed [ESUM_W+1:0] sum_raw, lim;
  logic signed [ESUM_W-1:0] err_sum_next;
  logic                     commanded, turning, move_next;

  always_comb begin
    odom_sum = {odom_now[SPD_W-1], odom_now} + {odom_before[SPD_W-1], odom_before};
    filt     = odom_sum[SPD_W:1];
    err_raw  = {prev_ang[SPD_W-1], prev_ang} - {filt[SPD_W-1], filt};
    err_next = (!prev_ang[SPD_W-1] && prev_ang != '0) ? err_raw : -err_raw;

    sum_raw = (ESUM_W+2)'(err_sum) + (ESUM_W+2)'(err_next);
    lim     = {3'b000, cfg.integral_limit};
    if (sum_raw > lim) begin
      err_sum_next = lim[ESUM_W-1:0];
    end else if (sum_raw < -lim) begin
      err_sum_next = ESUM_W'(-lim);
    end else begin
      err_sum_next = sum_raw[ESUM_W-1:0];
    end

    commanded = (mag(tgt_lin) > {8'd0, cfg.command_threshold}) ||
                (mag(prev_ang) > {8'd0, cfg.command_threshold});
    turning   = (mag(left_meas) >= {8'd0, cfg.wheel_threshold}) ||
                (mag(right_meas) >= {8'd0, cfg.wheel_threshold});
    move_next = commanded && turning;
  end

  // shared multiplier
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    unique case (cmd.mul_sel)
      scd_pkg::MUL_P: begin
        mul_a = MA_W'(err);
        mul_b = {1'b0, cfg.gain_p};
      end
      scd_pkg::MUL_I: begin
        mul_a = MA_W'(err_sum);
        mul_b = {1'b0, cfg.gain_i};
      end
      scd_pkg::MUL_D: begin
        mul_a = MA_W'(diff);
        mul_b = {1'b0, cfg.gain_d};
      end
      scd_pkg::MUL_ANG: begin
        mul_a = MA_W'(tgt_ang);
        mul_b = MB_W'(slip) + MB_W'(scd_pkg::SLIP_ONE);
      end
      scd_pkg::MUL_HWB: begin
        mul_a = prod[FRAC +: MA_W];   // angular term, already >> FRAC
        mul_b = {{(MB_W-13){1'b0}}, cfg.half_wheel_base};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // slip update
  logic signed [T_W-1:0]    slip_sum;
  logic signed [SLIP_W-1:0] slip_next;

  always_comb begin
    slip_sum = T_W'(slip) + T_W'($signed(acc[ACC_W-1:GFRAC]));
    if (slip_sum > T_W'(scd_pkg::SLIP_MAX)) begin
      slip_next = SLIP_W'(scd_pkg::SLIP_MAX);
    end else if (slip_sum < T_W'(scd_pkg::SLIP_MIN)) begin
      slip_next = SLIP_W'(scd_pkg::SLIP_MIN);
    end else begin
      slip_next = slip_sum[SLIP_W-1:0];
    end
  end

  // wheel commands
  logic signed [W_W-1:0]   wr_sum, wl_sum;
  logic signed [SPD_W-1:0] wr_sat, wl_sat;

  always_comb begin
    wr_sum = W_W'(tgt_lin) + W_W'($signed(prod[PROD_W-1:FRAC]));
    wl_sum = W_W'(tgt_lin) - W_W'($signed(prod[PROD_W-1:FRAC]));
    if (wr_sum > W_W'(scd_pkg::SPD_MAX)) begin
      wr_sat = SPD_W'(scd_pkg::SPD_MAX);
    end else if (wr_sum < W_W'(scd_pkg::SPD_MIN)) begin
      wr_sat = SPD_W'(scd_pkg::SPD_MIN);
    end else begin
      wr_sat = wr_sum[SPD_W-1:0];
    end
    if (wl_sum > W_W'(scd_pkg::SPD_MAX)) begin
      wl_sat = SPD_W'(scd_pkg::SPD_MAX);
    end else if (wl_sum < W_W'(scd_pkg::SPD_MIN)) begin
      wl_sat = SPD_W'(scd_pkg::SPD_MIN);
    end else begin
      wl_sat = wl_sum[SPD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_lin     <= '0;
      tgt_ang     <= '0;
      prev_ang    <= '0;
      odom_now    <= '0;
      odom_before <= '0;
      slip        <= '0;
      err_sum     <= '0;
      last_err    <= '0;
    end else begin
      if (cmd.capture && cmd_valid) begin
        prev_ang <= tgt_ang;
        tgt_lin  <= cmd_linear;
        tgt_ang  <= cmd_angular;
      end
      if (cmd.capture && odom_valid) begin
        odom_before <= odom_now;
        odom_now    <= odom_angular;
      end
      if (cmd.err_step && move_next) begin
        err_sum <= err_sum_next;
      end
      if (cmd.slip_step && move) begin
        slip     <= slip_next;
        last_err <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      right_meas <= wheel_right_meas;
      left_meas  <= wheel_left_meas;
    end
    if (cmd.err_step) begin
      err  <= err_next;
      move <= move_next;
    end
    if (cmd.diff_load) begin
      diff <= DIFF_W'(last_err) - DIFF_W'(err);
    end
    if (cmd.mul_en) begin
      prod <= mul_p;
    end
    if (cmd.acc_load) begin
      acc <= ACC_W'(prod);
    end else if (cmd.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.out_load) begin
      slip_value <= slip;
      if (tgt_lin == '0 && tgt_ang == '0) begin
        wheel_right_cmd <= '0;
        wheel_left_cmd  <= '0;
      end else begin
        wheel_right_cmd <= wr_sat;
        wheel_left_cmd  <= wl_sat;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/slip_compensated_diff_drive_core.sv =====
// ----------------------------------------------------------------------------
// slip_compensated_diff_drive_core - slip-compensated differential drive
// A new item is accepted only in ST_IDLE, once the previous result has been
// handed to the output register; all five products go through one
// shared 24x17 multiplier, sequenced by scd_ctrl.
// The output register lets the next item be accepted while a result waits.
// Reset (rst, synchronous) restores register defaults and zeroes tick state.
// ----------------------------------------------------------------------------
`default_nettype none

module slip_compensated_diff_drive_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input item
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [19:0] cmd_linear, [39:20] cmd_angular, [59:40] odom_angular,
  // [79:60] wheel_right_meas, [99:80] wheel_left_meas, [103:100] zero
  input  wire logic [scd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] cmd_valid, [1] odom_valid
  input  wire logic [scd_pkg::IN_USER_W-1:0]   s_axis_tuser,
  // result item
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [19:0] wheel_right_cmd, [39:20] wheel_left_cmd, [54:40] slip_value,
  // [55] zero
  output logic      [scd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [scd_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [scd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [scd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  scd_pkg::cfg_t    cfg;
  scd_pkg::dp_cmd_t cmd;

  logic signed [scd_pkg::SPD_W-1:0]  wheel_right_cmd, wheel_left_cmd;
  logic signed [scd_pkg::SLIP_W-1:0] slip_value;

  scd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  scd_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg              (cfg),
    .cmd_valid        (s_axis_tuser[0]),
    .cmd_linear       (s_axis_tdata[19:0]),
    .cmd_angular      (s_axis_tdata[39:20]),
    .odom_valid       (s_axis_tuser[1]),
    .odom_angular     (s_axis_tdata[59:40]),
    .wheel_right_meas (s_axis_tdata[79:60]),
    .wheel_left_meas  (s_axis_tdata[99:80]),
    .wheel_right_cmd  (wheel_right_cmd),
    .wheel_left_cmd   (wheel_left_cmd),
    .slip_value       (slip_value)
  );

  assign m_axis_tdata = {1'b0, slip_value, wheel_left_cmd, wheel_right_cmd};

endmodule

`default_nettype wire

// ===== test/slip_compensated_diff_drive_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slip_compensated_diff_drive_core_tb - self-checking bench for the drive core
// Sends control ticks over the input stream and rewrites the gain, limit and
// threshold registers between phases. Every wheel-command item is checked
// field by field against an in-bench fixed-point model of the slip PID update
// and the wheel mixing, or against the directed table's expected values.
// ----------------------------------------------------------------------------

module slip_compensated_diff_drive_core_tb;

  localparam int SPD_W        = scd_pkg::SPD_W;
  localparam int SLIP_W       = scd_pkg::SLIP_W;
  localparam int FRAC_BITS    = scd_pkg::FRAC_BITS;
  localparam int GAIN_FRAC    = scd_pkg::GAIN_FRAC;
  localparam int SLIP_ONE     = scd_pkg::SLIP_ONE;
  localparam int SPD_MAX      = scd_pkg::SPD_MAX;
  localparam int SPD_MIN      = scd_pkg::SPD_MIN;
  localparam int IN_DATA_W    = scd_pkg::IN_DATA_W;
  localparam int IN_USER_W    = scd_pkg::IN_USER_W;
  localparam int OUT_DATA_W   = scd_pkg::OUT_DATA_W;
  localparam int APB_ADDR_W   = scd_pkg::APB_ADDR_W;
  localparam int APB_DATA_W   = scd_pkg::APB_DATA_W;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DIR_N        = 21;
  localparam int CHUNKS       = 8;
  localparam int CHUNK_ITEMS  = 210;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int TOP          = SPD_MAX;
  localparam int BOT          = SPD_MIN;
  // index 7 has no register behind it
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 5'd28;

  typedef struct packed {
    logic signed [SPD_W-1:0]  right;
    logic signed [SPD_W-1:0]  left;
    logic signed [SLIP_W-1:0] slip;
  } wheel_cmd_t;

  typedef struct packed {
    logic                    cmd_v;
    logic signed [SPD_W-1:0] lin;
    logic signed [SPD_W-1:0] ang;
    logic                    odom_v;
    logic signed [SPD_W-1:0] odom;
    logic signed [SPD_W-1:0] wr;
    logic signed [SPD_W-1:0] wl;
    logic                    known;
    wheel_cmd_t              want;
  } tick_row_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic [IN_USER_W-1:0]   s_tuser = '0;
  logic                   m_tready = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;

  logic                   s_axis_tready;
  logic                   m_axis_tvalid;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  // model state and register copy
  scd_pkg::cfg_t cfg;
  longint tgt_lin, tgt_ang, prev_ang, odom_cur, odom_old, slip, err_sum, err_last;

  wheel_cmd_t wheel_cmd_queue [$];
  tick_row_t  dir_table [DIR_N];
  logic signed [SPD_W-1:0] last_ang = '0;
  int  send_idle = 0;
  int  stall_pct = 0;
  bit  hold_req  = 1'b0;
  int  hold_left = 0;
  int  mismatches = 0;
  int  cycle_count = 0;

  slip_compensated_diff_drive_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one control tick: take command, take odometry, slip PID, wheel mixing
  function automatic wheel_cmd_t drive_tick(tick_row_t t);
    longint one, wr, wl, filt, e, lim, acc, ang, d;
    logic commanded, turning;
    wheel_cmd_t res;
    one = longint'(SLIP_ONE);
    wr = longint'(t.wr);
    wl = longint'(t.wl);
    if (t.cmd_v) begin
      prev_ang = tgt_ang;
      tgt_lin  = longint'(t.lin);
      tgt_ang  = longint'(t.ang);
    end
    if (t.odom_v) begin
      odom_old = odom_cur;
      odom_cur = longint'(t.odom);
    end
    commanded = (mag(tgt_lin) > longint'(cfg.command_threshold)) ||
                (mag(prev_ang) > longint'(cfg.command_threshold));
    turning = (mag(wl) >= longint'(cfg.wheel_threshold)) ||
              (mag(wr) >= longint'(cfg.wheel_threshold));
    if (commanded && turning) begin
      filt = (odom_cur + odom_old) >>> 1;
      e = (prev_ang > 0) ? prev_ang - filt : filt - prev_ang;
      lim = longint'(cfg.integral_limit);
      err_sum = clip(err_sum + e, -lim, lim);
      acc = e * longint'(cfg.gain_p) + err_sum * longint'(cfg.gain_i) +
            (err_last - e) * longint'(cfg.gain_d);
      slip = clip(slip + (acc >>> GAIN_FRAC), -one, 2 * one);
      err_last = e;
    end
    res = '0;
    if (tgt_lin != 0 || tgt_ang != 0) begin
      ang = (tgt_ang * (one + slip)) >>> FRAC_BITS;
      d = (longint'(cfg.half_wheel_base) * ang) >>> FRAC_BITS;
      res.right = SPD_W'(clip(tgt_lin + d, SPD_MIN, SPD_MAX));
      res.left  = SPD_W'(clip(tgt_lin - d, SPD_MIN, SPD_MAX));
    end
    res.slip = SLIP_W'(slip);
    return res;
  endfunction

  function automatic void store_reg(logic [APB_ADDR_W-1:0] addr,
                                    logic [APB_DATA_W-1:0] data);
    case (addr[APB_ADDR_W-1:2])
      scd_pkg::REG_GAIN_P:       cfg.gain_p            = data[15:0];
      scd_pkg::REG_GAIN_I:       cfg.gain_i            = data[15:0];
      scd_pkg::REG_GAIN_D:       cfg.gain_d            = data[15:0];
      scd_pkg::REG_INT_LIMIT:    cfg.integral_limit    = data[18:0];
      scd_pkg::REG_HALF_BASE:    cfg.half_wheel_base   = data[12:0];
      scd_pkg::REG_CMD_THRESH:   cfg.command_threshold = data[11:0];
      scd_pkg::REG_WHEEL_THRESH: cfg.wheel_threshold   = data[11:0];
      default: ;
    endcase
  endfunction

  function automatic tick_row_t make_row(bit cmd_v, int lin, int ang, bit odom_v, int odom,
                                         int wr, int wl, bit known, int er, int el, int es);
    tick_row_t t;
    t.cmd_v      = cmd_v;
    t.lin        = SPD_W'(lin);
    t.ang        = SPD_W'(ang);
    t.odom_v     = odom_v;
    t.odom       = SPD_W'(odom);
    t.wr         = SPD_W'(wr);
    t.wl         = SPD_W'(wl);
    t.known      = known;
    t.want.right = SPD_W'(er);
    t.want.left  = SPD_W'(el);
    t.want.slip  = SLIP_W'(es);
    return t;
  endfunction

  // mostly modest speeds, some near the threshold, some full range
  function automatic logic signed [SPD_W-1:0] rand_speed(int thr);
    int v;
    case ($urandom_range(9))
      0, 1: v = int'($urandom);
      7: v = (thr + int'($urandom_range(4)) - 2) * ($urandom_range(1) ? 1 : -1);
      8: begin
        case ($urandom_range(3))
          0: v = TOP;
          1: v = BOT;
          2: v = 0;
          default: v = -1;
        endcase
      end
      9: v = int'($urandom_range(262143)) - 131072;
      default: v = int'($urandom_range(16383)) - 8192;
    endcase
    return SPD_W'(v);
  endfunction

  function automatic tick_row_t rand_tick();
    tick_row_t t;
    t = '0;
    t.cmd_v  = ($urandom_range(99) < 45);
    t.lin    = rand_speed(int'(cfg.command_threshold));
    t.ang    = rand_speed(int'(cfg.command_threshold));
    t.odom_v = ($urandom_range(99) < 60);
    // odometry usually follows the commanded yaw rate with some noise
    if ($urandom_range(99) < 70)
      t.odom = SPD_W'(int'(last_ang) + int'($urandom_range(2047)) - 1024);
    else
      t.odom = rand_speed(int'(cfg.command_threshold));
    t.wr = rand_speed(int'(cfg.wheel_threshold));
    t.wl = rand_speed(int'(cfg.wheel_threshold));
    if (t.cmd_v) last_ang = t.ang;
    return t;
  endfunction

  // valid is left high after accept; the next call either reloads or drops it
  task automatic offer_tick(input tick_row_t t, input int idle_pct);
    wheel_cmd_t res;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, t.wl, t.wr, t.odom, t.ang, t.lin};
    s_tuser  <= {t.odom_v, t.cmd_v};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    res = drive_tick(t);
    if (t.known) res = t.want;
    wheel_cmd_queue.push_back(res);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    store_reg(addr, data);
  endtask

  task automatic program_regs(input int unsigned vals [7]);
    for (int i = 0; i < 7; i++) apb_write({scd_pkg::reg_idx_t'(i), 2'b00}, vals[i]);
    apb_write(ADDR_UNMAPPED, $urandom);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] data);
    wheel_cmd_t got, want;
    got.right = data[19:0];
    got.left  = data[39:20];
    got.slip  = data[54:40];
    if (wheel_cmd_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] result item with none expected: %h", $time, data);
    end else begin
      want = wheel_cmd_queue.pop_front();
      if (got.right != want.right || got.left != want.left || got.slip != want.slip) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"[%0t] mismatch right exp %0d got %0d, left exp %0d got %0d,",
                    " slip exp %0d got %0d"},
                   $time, want.right, got.right, want.left, got.left, want.slip, got.slip);
      end
    end
  endtask

  // result side: check, then pick tready for the next cycle
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_tready) check_result(m_axis_tdata);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned vals [7];
    cfg = '{gain_p: 16'd655, gain_i: 16'd0, gain_d: 16'd0, integral_limit: 19'd40960,
            half_wheel_base: 13'd1434, command_threshold: 12'd41, wheel_threshold: 12'd20};
    {tgt_lin, tgt_ang, prev_ang, odom_cur, odom_old} = '0;
    {slip, err_sum, err_last} = '0;

    // wheel outputs are obvious while slip stays at zero
    dir_table[0]  = make_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    dir_table[1]  = make_row(0, 0, 0, 0, 0, TOP, BOT, 1, 0, 0, 0);
    dir_table[2]  = make_row(1, TOP, 0, 0, 0, 0, 0, 1, TOP, TOP, 0);
    dir_table[3]  = make_row(1, BOT, 0, 0, 0, 19, -19, 1, BOT, BOT, 0);
    dir_table[4]  = make_row(1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    dir_table[5]  = make_row(1, 0, 100000, 1, TOP, 0, 0, 0, 0, 0, 0);
    dir_table[6]  = make_row(1, 0, 100000, 1, BOT, 20, 0, 0, 0, 0, 0);
    dir_table[7]  = make_row(1, 41, -300000, 1, 20000, 0, -20, 0, 0, 0, 0);
    dir_table[8]  = make_row(1, TOP, TOP, 1, BOT, 5000, 5000, 0, 0, 0, 0);
    dir_table[9]  = make_row(1, BOT, BOT, 1, BOT, TOP, BOT, 0, 0, 0, 0);
    dir_table[10] = make_row(0, 0, 0, 1, TOP, 100, -100, 0, 0, 0, 0);
    dir_table[11] = make_row(1, 0, 0, 0, 0, 3000, 0, 0, 0, 0, 0);
    dir_table[12] = make_row(1, 0, 41, 0, 0, 3000, 0, 0, 0, 0, 0);
    dir_table[13] = make_row(1, 0, 42, 0, 0, 3000, 0, 0, 0, 0, 0);
    dir_table[14] = make_row(1, 0, TOP, 1, TOP, 1000, 0, 0, 0, 0, 0);
    dir_table[15] = make_row(1, 0, TOP, 1, TOP, 1000, 0, 0, 0, 0, 0);
    dir_table[16] = make_row(1, 0, 10000, 1, TOP, 0, 1000, 0, 0, 0, 0);
    dir_table[17] = make_row(0, 0, 0, 1, -3, 0, BOT, 0, 0, 0, 0);
    dir_table[18] = make_row(0, 0, 0, 1, -4, TOP, 0, 0, 0, 0, 0);
    dir_table[19] = make_row(1, 1000, -1000, 1, -1000, 500, 500, 0, 0, 0, 0);
    dir_table[20] = make_row(1, TOP, BOT, 0, 0, TOP, TOP, 0, 0, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) offer_tick(dir_table[i], 0);

    for (int k = 0; k < CHUNKS; k++) begin
      if (k > 0) begin
        s_tvalid <= 1'b0;
        while (wheel_cmd_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        case (k)
          1: vals = '{65535, 65535, 65535, 524287, 8191, 4095, 4095};
          2: vals = '{0, 0, 0, 0, 0, 0, 0};
          3, 5: vals = '{2000, 300, 1000, 20000, 2048, 41, 20};
          7: vals = '{655, 0, 0, 40960, 1434, 41, 20};
          // full 32-bit writes; only the low bits of each register stick
          default: for (int i = 0; i < 7; i++) vals[i] = $urandom;
        endcase
        program_regs(vals);
      end
      case (k % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 79; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 79; end
        default: begin send_idle = 36; stall_pct = 36; end
      endcase
      // long output stall while input keeps coming, so the core backs up
      if (k == 4) hold_req = 1'b1;
      for (int n = 0; n < CHUNK_ITEMS; n++) offer_tick(rand_tick(), send_idle);
    end

    s_tvalid <= 1'b0;
    while (wheel_cmd_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
